@@ rtl/core/sobm_pkg.sv @@
package sobm_pkg;

	localparam int PIX_W  = 8;
	localparam int POS_W  = 10;
	localparam int EDGE_W = 12;
	localparam int CFG_W  = 11;
	localparam int GRAD_W = 11;
	localparam int SQ_W   = 21;

	localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_OUTPUT_MODE  = 2'd2;

	localparam logic MODE_MAGNITUDE = 1'b0;
	localparam logic MODE_DERIV_X   = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;

	// [row][col], row 0 is the oldest line, col 0 the oldest column
	typedef pix_t [2:0][2:0] win_t;

	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		win_t             win;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SUM,
		BK_SQUARE,
		BK_ROOT,
		BK_DONE
	} back_state_t;

endpackage

@@ rtl/core/sobel_edge_magnitude_unit.sv @@
// Sobel 3x3 edge unit over a raster pixel stream.
// Input request: pixel and frame_start on in_valid/in_ready; frame_start marks
// row 0, column 0 and restarts the position count. Frame size comes from the
// frame_width and frame_height registers, clamped to 3..MAX_WIDTH/MAX_HEIGHT.
// Output request: center_row, center_col and edge_value on out_valid/out_ready,
// one per interior pixel, in raster order; border pixels give no request.
// Configuration: cfg_we, cfg_index (0 width, 1 height, 2 mode), cfg_data.
// The front takes one pixel per cycle, while the queue has room, into two line
// stores and a 3x3 window, and hands each complete window to a two-entry
// queue. The back works one window at a time: signed Gx after the sum state,
// or the magnitude after the square and root states, the square root unit
// resolving one result bit per cycle. When the receiver stalls the result
// holds, the queue fills, and then in_ready drops until the back frees an
// entry.
// Reset clears the position to row 0, column 0, empties the queue and sets the
// registers to 1024 x 1024, magnitude mode. Line stores need no clearing.
module sobel_edge_magnitude_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [sobm_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [sobm_pkg::PIX_W-1:0]          pixel,
	input  logic                                frame_start,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [sobm_pkg::POS_W-1:0]          center_row,
	output logic [sobm_pkg::POS_W-1:0]          center_col,
	output logic signed [sobm_pkg::EDGE_W-1:0]  edge_value
);

	logic [sobm_pkg::CFG_W-1:0] width_q, height_q;
	logic                       mode_q;

	logic           push, queue_full, pop, job_valid;
	sobm_pkg::job_t push_job, job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sobm_pkg::CFG_W'(1024);
			height_q <= sobm_pkg::CFG_W'(1024);
			mode_q   <= sobm_pkg::MODE_MAGNITUDE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sobm_pkg::CFG_FRAME_WIDTH:  width_q  <= cfg_data;
				sobm_pkg::CFG_FRAME_HEIGHT: height_q <= cfg_data;
				sobm_pkg::CFG_OUTPUT_MODE:  mode_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	sobm_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_width  (width_q),
		.frame_height (height_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel        (pixel),
		.frame_start  (frame_start),
		.push         (push),
		.push_job     (push_job),
		.queue_full   (queue_full)
	);

	sobm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (queue_full),
		.pop       (pop),
		.job_valid (job_valid),
		.job       (job)
	);

	sobm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.output_mode (mode_q),
		.job_valid   (job_valid),
		.job         (job),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.center_row  (center_row),
		.center_col  (center_col),
		.edge_value  (edge_value)
	);

endmodule

@@ rtl/core/sobm_front.sv @@
module sobm_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [sobm_pkg::CFG_W-1:0]   frame_width,
	input  logic [sobm_pkg::CFG_W-1:0]   frame_height,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [sobm_pkg::PIX_W-1:0]   pixel,
	input  logic                         frame_start,
	output logic                         push,
	output sobm_pkg::job_t               push_job,
	input  logic                         queue_full
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int WDW = (CW + 1 > sobm_pkg::CFG_W) ? CW + 1 : sobm_pkg::CFG_W;
	localparam int HDW = (RW + 1 > sobm_pkg::CFG_W) ? RW + 1 : sobm_pkg::CFG_W;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic [WDW-1:0] w_ext, w_use, c_next;
	logic [HDW-1:0] h_ext, h_use, r_inc, r_wrap, r_next;
	logic [CW-1:0]  col_base, c_sel, col_d;
	logic [RW-1:0]  row_base, r_sel, row_d;
	logic           col_wrap, c_end, emit;
	logic [HDW-1:0] crow_full;
	logic [WDW-1:0] ccol_full;
	logic           in_accept, s1_adv;

	sobm_pkg::pix_t upper_mem  [MAX_WIDTH];
	sobm_pkg::pix_t middle_mem [MAX_WIDTH];
	sobm_pkg::pix_t rd_up_q, rd_mid_q;

	logic                        valid_s1, emit_s1, fwd_s1;
	sobm_pkg::pix_t              px_s1, fup_s1, fmid_s1;
	logic [CW-1:0]               col_s1;
	logic [sobm_pkg::POS_W-1:0]  crow_s1, ccol_s1;
	sobm_pkg::pix_t              up_eff, mid_eff;
	sobm_pkg::win_t              win_q, win_d;

	// clamp frame size to the supported range
	always_comb begin
		w_ext = WDW'(frame_width);
		h_ext = HDW'(frame_height);
		if (w_ext < WDW'(3))
			w_use = WDW'(3);
		else if (w_ext > WDW'(MAX_WIDTH))
			w_use = WDW'(MAX_WIDTH);
		else
			w_use = w_ext;
		if (h_ext < HDW'(3))
			h_use = HDW'(3);
		else if (h_ext > HDW'(MAX_HEIGHT))
			h_use = HDW'(MAX_HEIGHT);
		else
			h_use = h_ext;
	end

	// position of the arriving pixel and of the one after it
	always_comb begin
		col_base = frame_start ? '0 : col_q;
		row_base = frame_start ? '0 : row_q;
		col_wrap = WDW'(col_base) >= w_use;
		c_sel    = col_wrap ? '0 : col_base;
		r_inc    = HDW'(row_base) + HDW'(col_wrap);
		r_wrap   = (r_inc >= h_use) ? '0 : r_inc;
		r_sel    = r_wrap[RW-1:0];

		c_next = WDW'(c_sel) + WDW'(1);
		c_end  = c_next >= w_use;
		r_next = HDW'(r_sel) + HDW'(1);
		col_d  = c_end ? '0 : c_next[CW-1:0];
		if (c_end)
			row_d = (r_next >= h_use) ? '0 : r_next[RW-1:0];
		else
			row_d = r_sel;

		emit      = (HDW'(r_sel) >= HDW'(2)) && (WDW'(c_sel) >= WDW'(2));
		crow_full = HDW'(r_sel) - HDW'(1);
		ccol_full = WDW'(c_sel) - WDW'(1);
	end

	assign s1_adv    = valid_s1 && !(emit_s1 && queue_full);
	assign in_ready  = !valid_s1 || s1_adv;
	assign in_accept = in_valid && in_ready;

	assign up_eff  = fwd_s1 ? fup_s1  : rd_up_q;
	assign mid_eff = fwd_s1 ? fmid_s1 : rd_mid_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_d[i][0] = win_q[i][1];
			win_d[i][1] = win_q[i][2];
		end
		win_d[0][2] = up_eff;
		win_d[1][2] = mid_eff;
		win_d[2][2] = px_s1;
	end

	assign push         = s1_adv && emit_s1;
	assign push_job.row = crow_s1;
	assign push_job.col = ccol_s1;
	assign push_job.win = win_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_accept) begin
				col_q <= col_d;
				row_q <= row_d;
			end
			if (in_accept)
				valid_s1 <= 1'b1;
			else if (s1_adv)
				valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			px_s1   <= pixel;
			col_s1  <= c_sel;
			emit_s1 <= emit;
			crow_s1 <= crow_full[sobm_pkg::POS_W-1:0];
			ccol_s1 <= ccol_full[sobm_pkg::POS_W-1:0];
			// the pending write lands on the same column: take its data
			fwd_s1  <= valid_s1 && (c_sel == col_s1);
			fup_s1  <= mid_eff;
			fmid_s1 <= px_s1;
		end
		if (s1_adv)
			win_q <= win_d;
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			rd_up_q  <= upper_mem[c_sel];
			rd_mid_q <= middle_mem[c_sel];
		end
		if (s1_adv) begin
			upper_mem[col_s1]  <= mid_eff;
			middle_mem[col_s1] <= px_s1;
		end
	end

endmodule

@@ rtl/core/sobm_queue.sv @@
module sobm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sobm_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           job_valid,
	output sobm_pkg::job_t job
);

	sobm_pkg::job_t mem_q [2];
	logic           wptr_q, rptr_q;
	logic [1:0]     count_q;

	assign full      = count_q == 2'd2;
	assign job_valid = count_q != 2'd0;
	assign job       = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wptr_q <= !wptr_q;
			if (pop)
				rptr_q <= !rptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= push_job;
	end

endmodule

@@ rtl/core/sobm_back.sv @@
module sobm_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                output_mode,
	input  logic                                job_valid,
	input  sobm_pkg::job_t                      job,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [sobm_pkg::POS_W-1:0]          center_row,
	output logic [sobm_pkg::POS_W-1:0]          center_col,
	output logic signed [sobm_pkg::EDGE_W-1:0]  edge_value
);

	localparam int GW = sobm_pkg::GRAD_W;
	localparam int QW = sobm_pkg::SQ_W;

	sobm_pkg::back_state_t state_q, state_d;

	sobm_pkg::win_t              win_q;
	logic signed [GW-1:0]        gx_q, gy_q, gx_d, gy_d;
	logic signed [2*GW-1:0]      sqx, sqy;
	logic [QW-1:0]               v_q, res_q, bit_q;
	logic [QW:0]                 trial;
	logic                        take;

	// grey levels widened so the kernel sums stay signed
	function automatic logic signed [GW-1:0] px(input sobm_pkg::pix_t p);
		px = GW'($signed({1'b0, p}));
	endfunction

	always_comb begin
		gx_d = (px(win_q[0][2]) + (px(win_q[1][2]) <<< 1) + px(win_q[2][2]))
		     - (px(win_q[0][0]) + (px(win_q[1][0]) <<< 1) + px(win_q[2][0]));
		gy_d = (px(win_q[2][0]) + (px(win_q[2][1]) <<< 1) + px(win_q[2][2]))
		     - (px(win_q[0][0]) + (px(win_q[0][1]) <<< 1) + px(win_q[0][2]));
		sqx  = gx_q * gx_q;
		sqy  = gy_q * gy_q;
		trial = {1'b0, res_q} + {1'b0, bit_q};
		take  = {1'b0, v_q} >= trial;
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			sobm_pkg::BK_IDLE: begin
				if (job_valid) begin
					pop     = 1'b1;
					state_d = sobm_pkg::BK_SUM;
				end
			end
			sobm_pkg::BK_SUM: begin
				state_d = (output_mode == sobm_pkg::MODE_DERIV_X) ?
				          sobm_pkg::BK_DONE : sobm_pkg::BK_SQUARE;
			end
			sobm_pkg::BK_SQUARE: state_d = sobm_pkg::BK_ROOT;
			sobm_pkg::BK_ROOT: begin
				if (bit_q[0])
					state_d = sobm_pkg::BK_DONE;
			end
			sobm_pkg::BK_DONE: begin
				if (out_ready)
					state_d = sobm_pkg::BK_IDLE;
			end
			default: state_d = sobm_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= sobm_pkg::BK_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			sobm_pkg::BK_IDLE: begin
				if (job_valid) begin
					win_q      <= job.win;
					center_row <= job.row;
					center_col <= job.col;
				end
			end
			sobm_pkg::BK_SUM: begin
				gx_q       <= gx_d;
				gy_q       <= gy_d;
				edge_value <= sobm_pkg::EDGE_W'(gx_d);
			end
			sobm_pkg::BK_SQUARE: begin
				v_q   <= QW'(sqx) + QW'(sqy);
				res_q <= '0;
				bit_q <= QW'(1) << (QW - 1);
			end
			sobm_pkg::BK_ROOT: begin
				// one result bit per cycle, top down
				if (take) begin
					v_q   <= v_q - trial[QW-1:0];
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q[0])
					edge_value <= $signed({1'b0, take ? (res_q[GW:1] + bit_q[GW-1:0])
					                                 : res_q[GW:1]});
			end
			sobm_pkg::BK_DONE: ;
			default: ;
		endcase
	end

	assign out_valid = state_q == sobm_pkg::BK_DONE;

endmodule

@@ tb/tb_sobel_edge_magnitude_unit.sv @@
module tb_sobel_edge_magnitude_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam int DIM_MAX = 1024;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int RANDOM_PIXELS = 480;

	typedef struct {
		sobm_pkg::pix_t px;
		logic sof;
		logic wait_drain;
	} pixel_req_t;

	typedef struct {
		logic [sobm_pkg::POS_W-1:0]         row;
		logic [sobm_pkg::POS_W-1:0]         col;
		logic signed [sobm_pkg::EDGE_W-1:0] val;
	} edge_res_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               cfg_we = 1'b0;
	logic [1:0]                         cfg_index = sobm_pkg::CFG_FRAME_WIDTH;
	logic [sobm_pkg::CFG_W-1:0]         cfg_data = '0;
	logic                               in_valid = 1'b0;
	logic                               in_ready;
	sobm_pkg::pix_t                     pixel = '0;
	logic                               frame_start = 1'b0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic [sobm_pkg::POS_W-1:0]         center_row;
	logic [sobm_pkg::POS_W-1:0]         center_col;
	logic signed [sobm_pkg::EDGE_W-1:0] edge_value;

	pixel_req_t pending_pixels[$];
	edge_res_t  expected_edges[$];
	int         send_idle_pct = 0;
	int         stall_pct = 0;
	int         cycle_count = 0;
	int         pixels_queued = 0;
	bit         failed = 1'b0;

	// predictor state
	sobm_pkg::pix_t             upper_mem [DIM_MAX];
	sobm_pkg::pix_t             middle_mem [DIM_MAX];
	sobm_pkg::pix_t             win [3][3];
	int                         row_pos = 0;
	int                         col_pos = 0;
	logic [sobm_pkg::CFG_W-1:0] width_reg = 11'd1024;
	logic [sobm_pkg::CFG_W-1:0] height_reg = 11'd1024;
	logic                       mode_reg = sobm_pkg::MODE_MAGNITUDE;

	sobel_edge_magnitude_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel       (pixel),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.center_row  (center_row),
		.center_col  (center_col),
		.edge_value  (edge_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int used_dim(logic [sobm_pkg::CFG_W-1:0] v);
		if (v < 3) return 3;
		if (v > DIM_MAX) return DIM_MAX;
		return int'(v);
	endfunction

	function automatic logic [sobm_pkg::GRAD_W-1:0] floor_root(int sq);
		logic [sobm_pkg::GRAD_W-1:0] root;
		logic [sobm_pkg::GRAD_W-1:0] trial;
		root = '0;
		for (int b = sobm_pkg::GRAD_W - 1; b >= 0; b--) begin
			trial = root | (sobm_pkg::GRAD_W'(1) << b);
			if (int'(trial) * int'(trial) <= sq) root = trial;
		end
		return root;
	endfunction

	function automatic sobm_pkg::pix_t rand_pixel();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return sobm_pkg::pix_t'($urandom);
		endcase
	endfunction

	task automatic shift_in_pixel(input sobm_pkg::pix_t px, input logic sof);
		int w, h, r, c, gx, gy;
		edge_res_t res;
		w = used_dim(width_reg);
		h = used_dim(height_reg);
		if (sof) begin
			row_pos = 0;
			col_pos = 0;
		end
		// wrap a position left beyond a shrunk frame
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h) row_pos = 0;
		r = row_pos;
		c = col_pos;
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = upper_mem[c];
		win[1][2] = middle_mem[c];
		win[2][2] = px;
		upper_mem[c] = middle_mem[c];
		middle_mem[c] = px;
		if (r >= 2 && c >= 2) begin
			gx = int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2])
				- int'(win[0][0]) - 2 * int'(win[1][0]) - int'(win[2][0]);
			gy = int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2])
				- int'(win[0][0]) - 2 * int'(win[0][1]) - int'(win[0][2]);
			res.row = sobm_pkg::POS_W'(r - 1);
			res.col = sobm_pkg::POS_W'(c - 1);
			if (mode_reg == sobm_pkg::MODE_DERIV_X) res.val = sobm_pkg::EDGE_W'(gx);
			else res.val = {1'b0, floor_root(gx * gx + gy * gy)};
			expected_edges.insert(expected_edges.size(), res);
		end
		col_pos = c + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= h) row_pos = 0;
		end
	endtask

	task automatic enqueue_pixel(input sobm_pkg::pix_t px, input logic sof, input logic hold);
		pixel_req_t req;
		req.px = px;
		req.sof = sof;
		req.wait_drain = hold;
		pending_pixels.insert(pending_pixels.size(), req);
	endtask

	task automatic add_pixels(input int n, input logic sof_first, input bit noisy,
			input bit wait_first);
		for (int k = 0; k < n; k++)
			enqueue_pixel(rand_pixel(),
				(k == 0) ? sof_first : (noisy && $urandom_range(3) == 0),
				wait_first && k == 0);
		pixels_queued += n;
	endtask

	task automatic write_regs(input logic [sobm_pkg::CFG_W-1:0] w,
			input logic [sobm_pkg::CFG_W-1:0] h, input logic mode);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= sobm_pkg::CFG_FRAME_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= sobm_pkg::CFG_FRAME_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_index <= sobm_pkg::CFG_OUTPUT_MODE;
		cfg_data <= {10'($urandom), mode};
		// the spare index must be ignored
		@(posedge clk);
		cfg_index <= CFG_SPARE;
		cfg_data <= sobm_pkg::CFG_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain_all();
		while (pending_pixels.size() != 0 || in_valid || expected_edges.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_idle(input int phase_no);
		case (phase_no % 4)
			0: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				send_idle_pct = 71;
				stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct = 71;
			end
			default: begin
				send_idle_pct = 8;
				stall_pct = 8;
			end
		endcase
	endtask

	// pixel request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			pixel <= '0;
			frame_start <= 1'b0;
		end else if (!in_valid || in_ready) begin
			// hold a marked pixel until every expected result is out
			if (pending_pixels.size() != 0
					&& !(pending_pixels[0].wait_drain
						&& (in_valid || expected_edges.size() != 0))
					&& $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				pixel <= pending_pixels[0].px;
				frame_start <= pending_pixels[0].sof;
				void'(pending_pixels.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_ready <= 1'b0;
		else out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// check results, then advance the predictor
	always @(posedge clk) begin
		edge_res_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_edges.size() == 0) begin
					$display("%0t: unexpected result row %0d col %0d value %0d",
						$time, center_row, center_col, edge_value);
					failed = 1'b1;
				end else begin
					want = expected_edges.pop_front();
					if (center_row !== want.row) begin
						$display("%0t: center_row expected %0d, got %0d",
							$time, want.row, center_row);
						failed = 1'b1;
					end
					if (center_col !== want.col) begin
						$display("%0t: center_col expected %0d, got %0d",
							$time, want.col, center_col);
						failed = 1'b1;
					end
					if (edge_value !== want.val) begin
						$display("%0t: edge_value expected %0d, got %0d",
							$time, want.val, edge_value);
						failed = 1'b1;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					sobm_pkg::CFG_FRAME_WIDTH:  width_reg = cfg_data;
					sobm_pkg::CFG_FRAME_HEIGHT: height_reg = cfg_data;
					sobm_pkg::CFG_OUTPUT_MODE:  mode_reg = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) shift_in_pixel(pixel, frame_start);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		sobm_pkg::pix_t step_up [9];
		sobm_pkg::pix_t step_down [9];
		sobm_pkg::pix_t corner [9];
		int phase, w, h, frames, kind, base;
		step_up = '{0, 0, 255, 0, 0, 255, 0, 0, 255};
		step_down = '{255, 255, 0, 255, 255, 0, 255, 255, 0};
		corner = '{0, 0, 0, 0, 255, 255, 0, 255, 255};

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// smallest frame, strongest rising and falling Gx; the second frame
		// restarts on its own after the last row and waits for the first result
		set_idle(0);
		write_regs(11'd3, 11'd3, sobm_pkg::MODE_DERIV_X);
		for (int k = 0; k < 9; k++) enqueue_pixel(step_up[k], k == 0, 1'b0);
		for (int k = 0; k < 9; k++) enqueue_pixel(step_down[k], 1'b0, k == 0);
		drain_all();

		// undersized width and height clamp to 3, magnitude mode
		set_idle(1);
		write_regs(11'd0, 11'd2, sobm_pkg::MODE_MAGNITUDE);
		for (int k = 0; k < 9; k++) enqueue_pixel(corner[k], k == 0, 1'b0);
		drain_all();

		base = pixels_queued;
		phase = 2;
		while (pixels_queued - base < RANDOM_PIXELS) begin
			set_idle(phase);
			w = ($urandom_range(7) == 0) ? $urandom_range(13, 48) : $urandom_range(3, 12);
			h = $urandom_range(3, 8);
			write_regs(sobm_pkg::CFG_W'(w), sobm_pkg::CFG_W'(h), 1'($urandom_range(1)));
			if (phase % 5 == 4) begin
				// stop inside the frame, then shrink it under the current position
				add_pixels($urandom_range(2 * w, w * h - 1), 1'b1, 1'b0, 1'b0);
				drain_all();
				write_regs(sobm_pkg::CFG_W'($urandom_range(3, w)),
					sobm_pkg::CFG_W'($urandom_range(3, h)), 1'($urandom_range(1)));
				add_pixels(40, 1'b0, 1'b0, 1'b0);
			end else begin
				frames = $urandom_range(2, 3);
				for (int f = 0; f < frames; f++) begin
					kind = (f == 0) ? 0 : $urandom_range(99);
					if (kind < 70)
						add_pixels(w * h, 1'b1, 1'b0, phase % 3 == 0 && f == 1);
					else if (kind < 80)
						add_pixels(w * h, 1'b0, 1'b0, 1'b0);
					else if (kind < 90)
						add_pixels($urandom_range(1, w * h - 1), 1'b1, 1'b0, 1'b0);
					else
						add_pixels(w * h, 1'b1, 1'b1, 1'b0);
				end
			end
			drain_all();
			phase++;
		end

		// oversized width and height writes, part of a first row, then shrink
		// the frame under that position and run on without a frame start
		set_idle(phase);
		write_regs(11'd2047, 11'd2047, sobm_pkg::MODE_MAGNITUDE);
		add_pixels(100, 1'b1, 1'b0, 1'b0);
		drain_all();
		phase++;
		set_idle(phase);
		write_regs(11'd5, 11'd4, sobm_pkg::MODE_DERIV_X);
		add_pixels(40, 1'b0, 1'b0, 1'b0);
		drain_all();

		if (!failed) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

endmodule
